// File: rtl/assert_macros.svh
// Assertion macros used by the output stage of the bounded random reduction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational invariant, checked on every rising clock edge outside reset.
`define BRR_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication into the next cycle, checked outside reset.
`define BRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/brr_pkg.sv
// Shared constants and types of the bounded random reduction pipeline.
package brr_pkg;

    localparam int WORD_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int PROD_BITS   = 2 * WORD_BITS;
    // remainder unit: bits of the dividend consumed per pipeline stage
    localparam int DIV_BITS    = 4;
    localparam int DIV_STAGES  = (WORD_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W       = DIV_STAGES * DIV_BITS;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_DOMAIN = 2'd1,
        STATUS_REJECT = 2'd2
    } status_t;

    typedef struct packed {
        logic                 zero_bound;
        logic                 pow2;
        logic [WORD_BITS-1:0] pow_value;
        logic [WORD_BITS-1:0] bound;
        logic [PROD_BITS-1:0] product;
        logic [DIV_W-1:0]     dividend;
        logic [WORD_BITS-1:0] rem;
    } stage_t;

endpackage

// File: rtl/bounded_random_reduce.sv
// Bounded random reduction: uniform random word and bound in, value below bound out.
//
// Input channel: in_valid/in_ready with random_word and bound; one transaction per item.
// Output channel: out_valid/out_ready with value and status; exactly one result per item.
// status: 0 value valid, 1 zero bound (domain error), 2 word rejected, supply a new one.
// value is zero unless status is 0.
// Pipeline: one input stage with the 32x32 multiplier, eight remainder stages of four
// bits each, one output register.
// Throughput: one item per cycle while out_ready is high; each stage holds its own valid bit.
// Receiver stall: the output register holds its result; stages behind it keep filling
// bubbles and in_ready drops only once the whole pipeline is full. Nothing is lost.
// Reset: clears all valid bits; the block is ready in the first cycle after reset.
module bounded_random_reduce (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [brr_pkg::WORD_BITS-1:0]   random_word,
    input  logic [brr_pkg::WORD_BITS-1:0]   bound,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [brr_pkg::WORD_BITS-1:0]   value,
    output logic [brr_pkg::STATUS_BITS-1:0] status
);

    brr_pkg::stage_t pipe_data  [brr_pkg::DIV_STAGES+1];
    logic            pipe_valid [brr_pkg::DIV_STAGES+1];
    logic            pipe_ready [brr_pkg::DIV_STAGES+1];

    brr_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .random_word (random_word),
        .bound       (bound),
        .out_valid   (pipe_valid[0]),
        .out_ready   (pipe_ready[0]),
        .out_data    (pipe_data[0])
    );

    for (genvar i = 0; i < brr_pkg::DIV_STAGES; i++)
    begin : g_div
        brr_div_stage u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[i]),
            .in_ready  (pipe_ready[i]),
            .in_data   (pipe_data[i]),
            .out_valid (pipe_valid[i+1]),
            .out_ready (pipe_ready[i+1]),
            .out_data  (pipe_data[i+1])
        );
    end

    brr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_valid[brr_pkg::DIV_STAGES]),
        .in_ready  (pipe_ready[brr_pkg::DIV_STAGES]),
        .in_data   (pipe_data[brr_pkg::DIV_STAGES]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status)
    );

endmodule

// File: rtl/brr_in_stage.sv
// Input stage: bound classification, wide product and remainder set-up.
module brr_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [brr_pkg::WORD_BITS-1:0] random_word,
    input  logic [brr_pkg::WORD_BITS-1:0] bound,
    output logic                          out_valid,
    input  logic                          out_ready,
    output brr_pkg::stage_t               out_data
);

    logic                          valid_reg;
    brr_pkg::stage_t               data_reg;
    brr_pkg::stage_t               data_next;
    logic [brr_pkg::WORD_BITS-1:0] bound_m1;
    logic [brr_pkg::WORD_BITS-1:0] neg_bound;

    assign bound_m1  = bound - brr_pkg::WORD_BITS'(1);
    // (2^W - bound) mod 2^W, the dividend of the threshold remainder
    assign neg_bound = ~bound + brr_pkg::WORD_BITS'(1);

    always_comb
    begin
        data_next            = '0;
        data_next.zero_bound = (bound == '0);
        data_next.pow2       = ((bound & bound_m1) == '0);
        data_next.pow_value  = random_word & bound_m1;
        data_next.bound      = bound;
        data_next.product    = brr_pkg::PROD_BITS'(random_word)
                             * brr_pkg::PROD_BITS'(bound);
        data_next.dividend   = brr_pkg::DIV_W'(neg_bound);
        data_next.rem        = '0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/brr_div_stage.sv
// One stage of the pipelined restoring remainder unit.
module brr_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  brr_pkg::stage_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output brr_pkg::stage_t out_data
);

    logic            valid_reg;
    brr_pkg::stage_t data_reg;
    brr_pkg::stage_t data_next;

    // consume DIV_BITS dividend bits, MSB first
    always_comb
    begin
        logic [brr_pkg::WORD_BITS:0]  rem_w;
        logic [brr_pkg::WORD_BITS:0]  bound_w;
        logic [brr_pkg::DIV_W-1:0]    dvd;
        rem_w   = {1'b0, in_data.rem};
        bound_w = {1'b0, in_data.bound};
        dvd     = in_data.dividend;
        for (int k = 0; k < brr_pkg::DIV_BITS; k++)
        begin
            rem_w = {rem_w[brr_pkg::WORD_BITS-1:0], dvd[brr_pkg::DIV_W-1]};
            dvd   = {dvd[brr_pkg::DIV_W-2:0], 1'b0};
            if (rem_w >= bound_w)
            begin
                rem_w = rem_w - bound_w;
            end
        end
        data_next          = in_data;
        data_next.dividend = dvd;
        data_next.rem      = rem_w[brr_pkg::WORD_BITS-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/brr_out_stage.sv
// Output stage: rejection test, result selection and output register.
`include "assert_macros.svh"

module brr_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  brr_pkg::stage_t                 in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [brr_pkg::WORD_BITS-1:0]   value,
    output logic [brr_pkg::STATUS_BITS-1:0] status
);

    logic                          valid_reg;
    logic [brr_pkg::WORD_BITS-1:0] value_reg;
    logic [brr_pkg::WORD_BITS-1:0] value_next;
    brr_pkg::status_t              status_reg;
    brr_pkg::status_t              status_next;
    logic [brr_pkg::WORD_BITS-1:0] prod_low;
    logic [brr_pkg::WORD_BITS-1:0] prod_high;

    assign prod_low  = in_data.product[brr_pkg::WORD_BITS-1:0];
    assign prod_high = in_data.product[brr_pkg::PROD_BITS-1:brr_pkg::WORD_BITS];

    always_comb
    begin
        value_next  = '0;
        status_next = brr_pkg::STATUS_OK;
        if (in_data.zero_bound)
        begin
            status_next = brr_pkg::STATUS_DOMAIN;
        end
        else if (in_data.pow2)
        begin
            value_next = in_data.pow_value;
        end
        else if (prod_low < in_data.rem)
        begin
            status_next = brr_pkg::STATUS_REJECT;
        end
        else
        begin
            value_next = prod_high;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    // remainder unit must leave the threshold below the bound
    `BRR_ASSERT_ALWAYS(a_rem_below_bound,
        !in_valid || in_data.zero_bound || in_data.rem < in_data.bound,
        "threshold remainder not below bound")
    // result (high half of word * bound, or masked word for a power of two) is below a nonzero bound
    `BRR_ASSERT_ALWAYS(a_value_below_bound,
        !in_valid || in_data.zero_bound || value_next < in_data.bound,
        "result not below bound")
    `BRR_ASSERT_NEXT(a_domain_status, in_valid && in_ready && in_data.zero_bound,
        status_reg == brr_pkg::STATUS_DOMAIN && value_reg == '0,
        "zero bound not flagged")

endmodule
